// ----- hw/rtl/parallel_lcd_bus_beat_sequencer_top_macros.svh -----
`ifndef PARALLEL_LCD_BUS_BEAT_SEQUENCER_TOP_MACROS_SVH
`define PARALLEL_LCD_BUS_BEAT_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication, quiet during reset
`define PLBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define PLBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, also checked across reset
`define PLBS_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/plbs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package plbs_pkg;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int CfgIdxW = 3;

  localparam logic [1:0] MODE_COMMAND = 2'd0;
  localparam logic [1:0] MODE_PARAM   = 2'd1;
  localparam logic [1:0] MODE_PIXEL   = 2'd2;

  localparam logic [1:0] ORDER_PLAIN     = 2'd0;
  localparam logic [1:0] ORDER_PAIR_SWAP = 2'd1;
  localparam logic [1:0] ORDER_BYTE_SWAP = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_BUS_IS_WIDE        = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_COMMAND_IS_WIDE    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_COMMAND_DC_LEVEL   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DATA_DC_LEVEL      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SELECT_ACTIVE_HIGH = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_COLOUR_ORDER       = 3'd5;

  typedef struct packed {
    logic       bus_is_wide;
    logic       command_is_wide;
    logic       command_dc_level;
    logic       data_dc_level;
    logic       select_active_high;
    logic [1:0] colour_order;
  } cfg_t;

  typedef struct packed {
    logic        two;
    logic        last;
    logic        sel;
    logic [15:0] b0_val;
    logic        b0_dc;
    logic [15:0] b1_val;
    logic        b1_dc;
  } beat_job_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/parallel_lcd_bus_beat_sequencer_top.sv -----
// channel  | signals                                        | direction
// s_axis   | tvalid tready tdata[15:0] tuser[1:0] tlast     | in  (value, mode, last)
// m_axis   | tvalid tready tdata[23:0] tuser tlast          | out (one write strobe per transfer)
// cfg      | cfg_valid cfg_ready cfg_index cfg_data         | in  (register writes)
//
// one input transfer yields zero, one or two strobes; a 4-entry job queue sits between
// the classifying front end and the strobe generator, which emits one strobe per cycle while
// a job is queued and the output is not stalled; a two-strobe job leaves the queue with its second strobe
// input is stalled only when the job queue is full; output stalls hold the strobe register
// synchronous reset clears queue pointers, output valid, pending word flag and half flag, and sets config defaults
`timescale 1ns / 1ps
`default_nettype none
module parallel_lcd_bus_beat_sequencer_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // value[15:0]
  input  logic [1:0]                    s_axis_tuser,  // mode[1:0]
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,  // bus_value[15:0], select_level[16],
                                                       // last_beat[17], zeros
  output logic                          m_axis_tuser,  // dc_level
  output logic                          m_axis_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [plbs_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [1:0]                    cfg_data
);
  import plbs_pkg::*;

  beat_job_t   push_job;
  beat_job_t   head;
  q_status_t   q_status;
  logic        push;
  logic        pop;
  logic [15:0] bus_value;
  logic        select_level;
  logic        last_beat;

  plbs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_axis_tvalid),
    .s_tready  (s_axis_tready),
    .mode      (s_axis_tuser),
    .value     (s_axis_tdata),
    .last      (s_axis_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_status  (q_status),
    .push      (push),
    .push_job  (push_job)
  );

  plbs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  plbs_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .q_status        (q_status),
    .pop             (pop),
    .m_tvalid        (m_axis_tvalid),
    .m_tready        (m_axis_tready),
    .bus_value       (bus_value),
    .dc_level        (m_axis_tuser),
    .select_level    (select_level),
    .last_beat       (last_beat),
    .end_transaction (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b000000, last_beat, select_level, bus_value};

endmodule
`default_nettype wire

// ----- hw/rtl/plbs_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module plbs_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [1:0]                    mode,
  input  logic [15:0]                   value,
  input  logic                          last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [plbs_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [1:0]                    cfg_data,
  input  plbs_pkg::q_status_t           q_status,
  output logic                          push,
  output plbs_pkg::beat_job_t           push_job
);
  import plbs_pkg::*;

  cfg_t        cfg;
  logic        pending_valid;
  logic [15:0] pending_word;
  logic        pending_valid_next;
  logic [15:0] pending_word_next;
  logic        accept;
  logic        gen;
  logic        cmd_dc;
  logic [1:0]  order;
  logic [15:0] hi;
  logic [15:0] lo;
  logic [15:0] swapped;

  assign s_tready  = !q_status.full;
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign push      = accept && gen;

  always_comb begin
    order   = (cfg.colour_order == ORDER_PAIR_SWAP || cfg.colour_order == ORDER_BYTE_SWAP)
              ? cfg.colour_order : ORDER_PLAIN;
    hi      = {8'h00, value[15:8]};
    lo      = {8'h00, value[7:0]};
    swapped = {value[7:0], value[15:8]};
    cmd_dc  = (mode == MODE_COMMAND) ? cfg.command_dc_level : cfg.data_dc_level;
    gen                = 1'b0;
    pending_valid_next = pending_valid;
    pending_word_next  = pending_word;
    push_job.two    = 1'b0;
    push_job.last   = last;
    push_job.sel    = cfg.select_active_high;
    push_job.b0_val = value;
    push_job.b0_dc  = cfg.data_dc_level;
    push_job.b1_val = value;
    push_job.b1_dc  = cfg.data_dc_level;
    if (mode == MODE_COMMAND || mode == MODE_PARAM || mode == MODE_PIXEL) begin
      if (!cfg.bus_is_wide) begin
        gen = 1'b1;
        if (mode == MODE_COMMAND) begin
          push_job.b0_dc = cfg.command_dc_level;
          push_job.b1_dc = cfg.command_dc_level;
          if (cfg.command_is_wide) begin
            push_job.two    = 1'b1;
            push_job.b0_val = hi;
            push_job.b1_val = lo;
          end else begin
            push_job.b0_val = lo;
          end
        end else if (mode == MODE_PARAM) begin
          push_job.b0_val = lo;
        end else begin
          push_job.two = 1'b1;
          if (order == ORDER_PLAIN) begin
            push_job.b0_val = lo;
            push_job.b1_val = hi;
          end else begin
            push_job.b0_val = hi;
            push_job.b1_val = lo;
          end
        end
      end else if (mode == MODE_PIXEL) begin
        if (order == ORDER_PAIR_SWAP) begin
          if (pending_valid) begin
            gen                = 1'b1;
            push_job.two       = 1'b1;
            push_job.b1_val    = pending_word;
            pending_valid_next = 1'b0;
            pending_word_next  = 16'h0000;
          end else if (last) begin
            gen = 1'b1;
          end else begin
            pending_valid_next = 1'b1;
            pending_word_next  = value;
          end
        end else begin
          gen = 1'b1;
          if (order == ORDER_BYTE_SWAP) begin
            push_job.b0_val = swapped;
          end
        end
      end else begin
        gen = 1'b1;
        if (pending_valid) begin
          push_job.two       = 1'b1;
          push_job.b0_val    = pending_word;
          push_job.b1_dc     = cmd_dc;
          pending_valid_next = 1'b0;
          pending_word_next  = 16'h0000;
        end else begin
          push_job.b0_dc = cmd_dc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bus_is_wide        <= 1'b0;
      cfg.command_is_wide    <= 1'b0;
      cfg.command_dc_level   <= 1'b0;
      cfg.data_dc_level      <= 1'b1;
      cfg.select_active_high <= 1'b0;
      cfg.colour_order       <= ORDER_PLAIN;
      pending_valid          <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BUS_IS_WIDE: begin
          cfg.bus_is_wide <= cfg_data[0];
          pending_valid   <= 1'b0;
        end
        REG_COMMAND_IS_WIDE:    cfg.command_is_wide    <= cfg_data[0];
        REG_COMMAND_DC_LEVEL:   cfg.command_dc_level   <= cfg_data[0];
        REG_DATA_DC_LEVEL:      cfg.data_dc_level      <= cfg_data[0];
        REG_SELECT_ACTIVE_HIGH: cfg.select_active_high <= cfg_data[0];
        REG_COLOUR_ORDER: begin
          cfg.colour_order <= cfg_data;
          pending_valid    <= 1'b0;
        end
        default: ;
      endcase
    end else if (accept) begin
      pending_valid <= pending_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pending_word <= pending_word_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/plbs_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module plbs_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  plbs_pkg::beat_job_t push_job,
  input  logic                pop,
  output plbs_pkg::beat_job_t head,
  output plbs_pkg::q_status_t q_status
);
  import plbs_pkg::*;

  beat_job_t        entries [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QPtrW:0]   count;

  assign head               = entries[rd_ptr];
  assign q_status.full      = (count == (QPtrW + 1)'(QDepth));
  assign q_status.not_empty = (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/plbs_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module plbs_back (
  input  logic                clk,
  input  logic                rst,
  input  plbs_pkg::beat_job_t head,
  input  plbs_pkg::q_status_t q_status,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [15:0]         bus_value,
  output logic                dc_level,
  output logic                select_level,
  output logic                last_beat,
  output logic                end_transaction
);
  import plbs_pkg::*;

  logic out_valid;
  logic half;
  logic load;
  logic first_of_two;

  assign m_tvalid     = out_valid;
  assign load         = !out_valid || m_tready;
  assign first_of_two = head.two && !half;
  assign pop          = load && q_status.not_empty && !first_of_two;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      half      <= 1'b0;
    end else if (load) begin
      out_valid <= q_status.not_empty;
      if (q_status.not_empty) begin
        half <= first_of_two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_status.not_empty) begin
      select_level <= head.sel;
      if (first_of_two) begin
        bus_value       <= head.b0_val;
        dc_level        <= head.b0_dc;
        last_beat       <= 1'b0;
        end_transaction <= 1'b0;
      end else begin
        bus_value       <= head.two ? head.b1_val : head.b0_val;
        dc_level        <= head.two ? head.b1_dc : head.b0_dc;
        last_beat       <= 1'b1;
        end_transaction <= head.last;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/plbs_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "parallel_lcd_bus_beat_sequencer_top_macros.svh"
module plbs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [23:0]                   m_axis_tdata,
  input logic                          m_axis_tuser,
  input logic                          m_axis_tlast,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [plbs_pkg::CfgIdxW-1:0]  cfg_index,
  input logic [1:0]                    cfg_data
);
  import plbs_pkg::*;

  logic wide_bus;

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_bus <= 1'b0;
    end else if (cfg_valid && cfg_ready && cfg_index == REG_BUS_IS_WIDE) begin
      wide_bus <= cfg_data[0];
    end
  end

  `PLBS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled strobe changed")
  `PLBS_ASSERT_ALWAYS_NEXT(a_reset_idle, rst, !m_axis_tvalid, "strobe valid right after reset")
  `PLBS_ASSERT_NOW(a_end_on_final, m_axis_tvalid && m_axis_tlast, m_axis_tdata[17], "transaction end on a non-final strobe")
  `PLBS_ASSERT_NOW(a_narrow_upper, m_axis_tvalid && !wide_bus, m_axis_tdata[15:8] == 8'h00, "upper lines driven on narrow bus")

endmodule

bind parallel_lcd_bus_beat_sequencer_top plbs_checker u_plbs_checker (.*);
`default_nettype wire
